>>> hdl/gcrc_pkg.sv
// Shared types and constants for the grow chamber relay controller.
// Used by gcrc_tick and grow_chamber_relay_controller; depends on nothing.
package gcrc_pkg;

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AIR_TEMP_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_TEMP_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_TIMING      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_HIGH        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LIMITS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NUTRIENT_LIMITS = 3'd7;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_AIR_TEMP_HIGH   = 8'd35;
  localparam logic [7:0]  RST_AIR_TEMP_LOW    = 8'd15;
  localparam logic [6:0]  RST_HUMIDITY_LOW    = 7'd50;
  localparam logic [6:0]  RST_HUMIDITY_HIGH   = 7'd85;
  localparam logic [31:0] RST_FOG_TIMING      = 32'd1966085;
  localparam logic [15:0] RST_CO2_HIGH        = 16'd2000;
  localparam logic [31:0] RST_LIGHT_LIMITS    = 32'd1638405000;
  localparam logic [15:0] RST_NUTRIENT_LIMITS = 16'd7698;

  // Relay bit positions
  localparam int BIT_FAN    = 0;
  localparam int BIT_HEATER = 1;
  localparam int BIT_FOG    = 2;
  localparam int BIT_LIGHT  = 3;
  localparam int BIT_COOLER = 4;
  localparam int BIT_PUMP   = 5;

  // Hysteresis bands
  localparam logic signed [9:0] TEMP_BAND = 10'sd2;
  localparam logic [7:0]        HUM_BAND  = 8'd5;

  // Fog phases
  localparam logic [1:0] FOG_STOPPED  = 2'd0;
  localparam logic [1:0] FOG_SPRAYING = 2'd1;
  localparam logic [1:0] FOG_PAUSING  = 2'd2;

  localparam logic MODE_MANUAL = 1'b1;

  typedef struct packed {
    logic [7:0]  air_temp_high;
    logic [7:0]  air_temp_low;
    logic [6:0]  hum_lo_pct;
    logic [6:0]  hum_hi_pct;
    logic [31:0] fog_timing;
    logic [15:0] co2_limit;
    logic [31:0] light_limits;
    logic [15:0] nutrient_limits;
  } gcrc_cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  manual_mask;
    logic [31:0] now_seconds;
    logic [7:0]  air_temp;
    logic [6:0]  humidity;
    logic [15:0] co2_ppm;
    logic [15:0] light_lux;
    logic [7:0]  nutr_temp;
    logic        water_valid;
    logic        water_low;
  } gcrc_item_t;

  typedef struct packed {
    logic [7:0]  relay;
    logic        fan_hold;
    logic        heat_hold;
    logic        fog_active;
    logic [1:0]  fog_state;
    logic [31:0] fog_mark;
  } gcrc_state_t;

endpackage

>>> hdl/gcrc_tick.sv
// Control tick logic: next controller state from one item, the current state
// and the configuration. Purely combinational; depends on gcrc_pkg.
module gcrc_tick (
  input  gcrc_pkg::gcrc_cfg_t   cfg,
  input  gcrc_pkg::gcrc_item_t  item,
  input  gcrc_pkg::gcrc_state_t state_cur,
  output gcrc_pkg::gcrc_state_t state_nxt
);

  logic signed [9:0] at_w;
  logic signed [9:0] ath_w;
  logic signed [9:0] atl_w;
  logic signed [9:0] nt_w;
  logic signed [9:0] ct_w;
  logic signed [9:0] ht_w;
  logic [7:0]        hum_w;
  logic [7:0]        hl_w;
  logic [7:0]        hh_w;
  logic [15:0]       spray_w;
  logic [15:0]       pause_w;
  logic [31:0]       elapsed_w;

  assign at_w    = 10'($signed(item.air_temp));
  assign ath_w   = 10'($signed(cfg.air_temp_high));
  assign atl_w   = 10'($signed(cfg.air_temp_low));
  assign nt_w    = 10'($signed(item.nutr_temp));
  assign ct_w    = 10'($signed(cfg.nutrient_limits[15:8]));
  assign ht_w    = 10'($signed(cfg.nutrient_limits[7:0]));
  assign hum_w   = {1'b0, item.humidity};
  assign hl_w    = {1'b0, cfg.hum_lo_pct};
  assign hh_w    = {1'b0, cfg.hum_hi_pct};
  assign spray_w = cfg.fog_timing[15:0];
  assign pause_w = cfg.fog_timing[31:16];

  always_comb begin
    state_nxt = state_cur;
    elapsed_w = '0;
    if (item.mode == gcrc_pkg::MODE_MANUAL) begin
      state_nxt.relay = item.manual_mask;
    end else begin
      // air temperature
      if (at_w > ath_w) begin
        if (!state_nxt.fan_hold) begin
          state_nxt.fan_hold = 1'b1;
          state_nxt.relay[gcrc_pkg::BIT_FAN] = 1'b1;
        end
      end else if (at_w < ath_w - gcrc_pkg::TEMP_BAND) begin
        state_nxt.fan_hold = 1'b0;
        state_nxt.relay[gcrc_pkg::BIT_FAN] = 1'b0;
      end
      if (at_w < atl_w) begin
        if (!state_nxt.heat_hold) begin
          state_nxt.heat_hold = 1'b1;
          state_nxt.relay[gcrc_pkg::BIT_HEATER] = 1'b1;
        end
      end else if (at_w > atl_w + gcrc_pkg::TEMP_BAND) begin
        state_nxt.heat_hold = 1'b0;
        state_nxt.relay[gcrc_pkg::BIT_HEATER] = 1'b0;
      end

      // humidity and fog
      if (hum_w < hl_w) begin
        if (!state_nxt.fog_active) begin
          state_nxt.fog_active = 1'b1;
          state_nxt.fog_state  = gcrc_pkg::FOG_SPRAYING;
          state_nxt.fog_mark   = item.now_seconds;
          state_nxt.relay[gcrc_pkg::BIT_FOG] = 1'b1;
        end
      end else if (hum_w > hl_w + gcrc_pkg::HUM_BAND) begin
        state_nxt.fog_active = 1'b0;
        state_nxt.fog_state  = gcrc_pkg::FOG_STOPPED;
        state_nxt.relay[gcrc_pkg::BIT_FOG] = 1'b0;
      end
      // a fresh start sees zero elapsed time here
      elapsed_w = item.now_seconds - state_nxt.fog_mark;
      if (state_nxt.fog_active) begin
        if (state_nxt.fog_state == gcrc_pkg::FOG_SPRAYING) begin
          if (elapsed_w >= {16'd0, spray_w}) begin
            state_nxt.fog_state = gcrc_pkg::FOG_PAUSING;
            state_nxt.fog_mark  = item.now_seconds;
            state_nxt.relay[gcrc_pkg::BIT_FOG] = 1'b0;
          end
        end else if (state_nxt.fog_state == gcrc_pkg::FOG_PAUSING) begin
          if (elapsed_w >= {16'd0, pause_w}) begin
            state_nxt.fog_state = gcrc_pkg::FOG_SPRAYING;
            state_nxt.fog_mark  = item.now_seconds;
            state_nxt.relay[gcrc_pkg::BIT_FOG] = 1'b1;
          end
        end
      end
      if (hum_w > hh_w) begin
        state_nxt.relay[gcrc_pkg::BIT_FAN] = 1'b1;
      end

      // CO2
      if (item.co2_ppm > cfg.co2_limit) begin
        state_nxt.relay[gcrc_pkg::BIT_FAN] = 1'b1;
      end

      // light
      if (item.light_lux < cfg.light_limits[15:0]) begin
        state_nxt.relay[gcrc_pkg::BIT_LIGHT] = 1'b1;
      end else if (item.light_lux > cfg.light_limits[31:16]) begin
        state_nxt.relay[gcrc_pkg::BIT_LIGHT] = 1'b0;
      end

      // nutrient temperature; the heater check runs last and wins
      if (nt_w > ct_w) begin
        state_nxt.relay[gcrc_pkg::BIT_COOLER] = 1'b1;
        state_nxt.relay[gcrc_pkg::BIT_HEATER] = 1'b0;
      end else if (nt_w < ct_w - gcrc_pkg::TEMP_BAND) begin
        state_nxt.relay[gcrc_pkg::BIT_COOLER] = 1'b0;
      end
      if (nt_w < ht_w) begin
        state_nxt.relay[gcrc_pkg::BIT_HEATER] = 1'b1;
        state_nxt.relay[gcrc_pkg::BIT_COOLER] = 1'b0;
      end else if (nt_w > ht_w + gcrc_pkg::TEMP_BAND) begin
        state_nxt.relay[gcrc_pkg::BIT_HEATER] = 1'b0;
      end

      // water level
      if (!item.water_valid || item.water_low) begin
        state_nxt.relay[gcrc_pkg::BIT_PUMP] = 1'b0;
      end
    end
  end

endmodule

>>> hdl/grow_chamber_relay_controller.sv
// Grow chamber relay controller, top level.
// Path: the input register, then the tick logic, then the result register.
// Throughput: one item per cycle while out_stall does not hold a result in the result register.
// Reset (synchronous, rst_n low): controller state and its relay bits cleared, both
// stages emptied, configuration registers loaded with their default values.
// Depends on gcrc_pkg and gcrc_tick.
module grow_chamber_relay_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_manual_mask,
  input  logic [31:0] in_now_seconds,
  input  logic signed [7:0] in_air_temp,
  input  logic [6:0]  in_humidity,
  input  logic [15:0] in_co2_ppm,
  input  logic [15:0] in_light_lux,
  input  logic signed [7:0] in_nutrient_temp,
  input  logic        in_water_valid,
  input  logic        in_water_low,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_relay_byte,
  output logic [1:0]  out_fog_step,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gcrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  gcrc_pkg::gcrc_cfg_t   cfg_r;
  gcrc_pkg::gcrc_item_t  item_r;
  gcrc_pkg::gcrc_state_t state_r;
  gcrc_pkg::gcrc_state_t state_nxt;
  logic                  item_valid_r;
  logic                  out_valid_r;
  logic [7:0]            out_relay_r;
  logic [1:0]            out_fog_r;
  logic                  advance;
  logic                  in_accept;

  assign cfg_ready = 1'b1;

  // move the held item into the result register when that register is empty or its result leaves now
  assign advance   = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = item_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_relay_byte = out_relay_r;
  assign out_fog_step   = out_fog_r;

  gcrc_tick u_tick (
    .cfg       (cfg_r),
    .item      (item_r),
    .state_cur (state_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.air_temp_high   <= gcrc_pkg::RST_AIR_TEMP_HIGH;
      cfg_r.air_temp_low    <= gcrc_pkg::RST_AIR_TEMP_LOW;
      cfg_r.hum_lo_pct      <= gcrc_pkg::RST_HUMIDITY_LOW;
      cfg_r.hum_hi_pct      <= gcrc_pkg::RST_HUMIDITY_HIGH;
      cfg_r.fog_timing      <= gcrc_pkg::RST_FOG_TIMING;
      cfg_r.co2_limit       <= gcrc_pkg::RST_CO2_HIGH;
      cfg_r.light_limits    <= gcrc_pkg::RST_LIGHT_LIMITS;
      cfg_r.nutrient_limits <= gcrc_pkg::RST_NUTRIENT_LIMITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcrc_pkg::REG_AIR_TEMP_HIGH:   cfg_r.air_temp_high   <= cfg_data[7:0];
        gcrc_pkg::REG_AIR_TEMP_LOW:    cfg_r.air_temp_low    <= cfg_data[7:0];
        gcrc_pkg::REG_HUMIDITY_LOW:    cfg_r.hum_lo_pct      <= cfg_data[6:0];
        gcrc_pkg::REG_HUMIDITY_HIGH:   cfg_r.hum_hi_pct      <= cfg_data[6:0];
        gcrc_pkg::REG_FOG_TIMING:      cfg_r.fog_timing      <= cfg_data;
        gcrc_pkg::REG_CO2_HIGH:        cfg_r.co2_limit       <= cfg_data[15:0];
        gcrc_pkg::REG_LIGHT_LIMITS:    cfg_r.light_limits    <= cfg_data;
        gcrc_pkg::REG_NUTRIENT_LIMITS: cfg_r.nutrient_limits <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.mode          <= in_mode;
      item_r.manual_mask   <= in_manual_mask;
      item_r.now_seconds   <= in_now_seconds;
      item_r.air_temp      <= in_air_temp;
      item_r.humidity      <= in_humidity;
      item_r.co2_ppm       <= in_co2_ppm;
      item_r.light_lux     <= in_light_lux;
      item_r.nutr_temp     <= in_nutrient_temp;
      item_r.water_valid   <= in_water_valid;
      item_r.water_low     <= in_water_low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_accept) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_relay_r <= state_nxt.relay;
      out_fog_r   <= state_nxt.fog_state;
    end
  end

  // fog is active exactly when a phase other than stopped is held
  a_fog_phase_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fog_active == (state_r.fog_state != gcrc_pkg::FOG_STOPPED))
    else $error("fog_active and fog phase disagree");

  a_fog_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fog_state == gcrc_pkg::FOG_STOPPED ||
    state_r.fog_state == gcrc_pkg::FOG_SPRAYING ||
    state_r.fog_state == gcrc_pkg::FOG_PAUSING)
    else $error("illegal fog phase");

  // a result leaving the tick logic matches the state it committed
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_relay_r == state_r.relay &&
                out_fog_r == state_r.fog_state)
    else $error("result register disagrees with committed state");

endmodule

>>> bench/testbench.sv
// Self-checking bench for grow_chamber_relay_controller: directed and random control ticks,
// configuration sweeps and idle/stall pressure, checked against an in-bench predictor.
// Depends on gcrc_pkg and the controller RTL.
module testbench;

  localparam logic MODE_AUTO = ~gcrc_pkg::MODE_MANUAL;
  localparam int QUIET_LIMIT = 2000;
  localparam int IDX_W = gcrc_pkg::CFG_IDX_W;

  typedef struct packed {
    logic [7:0] relay_byte;
    logic [1:0] fog_step;
  } relay_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gcrc_pkg::gcrc_item_t in_tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_relay_byte;
  logic [1:0] out_fog_step;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gcrc_pkg::gcrc_cfg_t setting;
  gcrc_pkg::gcrc_state_t chamber;
  relay_result_t expected_relays[$];
  logic [31:0] tick_now = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  grow_chamber_relay_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_tick.mode),
    .in_manual_mask(in_tick.manual_mask),
    .in_now_seconds(in_tick.now_seconds),
    .in_air_temp(in_tick.air_temp),
    .in_humidity(in_tick.humidity),
    .in_co2_ppm(in_tick.co2_ppm),
    .in_light_lux(in_tick.light_lux),
    .in_nutrient_temp(in_tick.nutr_temp),
    .in_water_valid(in_tick.water_valid),
    .in_water_low(in_tick.water_low),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_relay_byte(out_relay_byte),
    .out_fog_step(out_fog_step),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sdeg(logic [7:0] v);
    return int'($signed(v));
  endfunction

  function automatic logic [15:0] near(int center, int spread);
    return 16'(center + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic gcrc_pkg::gcrc_cfg_t default_setting();
    gcrc_pkg::gcrc_cfg_t s;
    s.air_temp_high   = gcrc_pkg::RST_AIR_TEMP_HIGH;
    s.air_temp_low    = gcrc_pkg::RST_AIR_TEMP_LOW;
    s.hum_lo_pct      = gcrc_pkg::RST_HUMIDITY_LOW;
    s.hum_hi_pct      = gcrc_pkg::RST_HUMIDITY_HIGH;
    s.fog_timing      = gcrc_pkg::RST_FOG_TIMING;
    s.co2_limit       = gcrc_pkg::RST_CO2_HIGH;
    s.light_limits    = gcrc_pkg::RST_LIGHT_LIMITS;
    s.nutrient_limits = gcrc_pkg::RST_NUTRIENT_LIMITS;
    return s;
  endfunction

  function automatic gcrc_pkg::gcrc_cfg_t random_setting();
    gcrc_pkg::gcrc_cfg_t s;
    s.air_temp_high   = 8'($urandom_range(165) - 40);
    s.air_temp_low    = 8'($urandom_range(165) - 40);
    s.hum_lo_pct      = 7'($urandom_range(100));
    s.hum_hi_pct      = 7'($urandom_range(100));
    s.fog_timing      = {16'($urandom_range(12)), 16'($urandom_range(8))};
    s.co2_limit       = 16'($urandom);
    s.light_limits    = $urandom;
    s.nutrient_limits = {8'($urandom_range(165) - 40), 8'($urandom_range(165) - 40)};
    return s;
  endfunction

  // One control tick: update the chamber state and return the relay byte and fog phase it leaves.
  function automatic relay_result_t advance_chamber(gcrc_pkg::gcrc_item_t t);
    logic [7:0] r;
    logic [31:0] elapsed;
    int at, nt, cool_t, heat_t, hi_t, lo_t;
    relay_result_t res;
    r = chamber.relay;
    if (t.mode == gcrc_pkg::MODE_MANUAL) begin
      r = t.manual_mask;
    end else begin
      at = sdeg(t.air_temp);
      nt = sdeg(t.nutr_temp);
      hi_t = sdeg(setting.air_temp_high);
      lo_t = sdeg(setting.air_temp_low);
      cool_t = sdeg(setting.nutrient_limits[15:8]);
      heat_t = sdeg(setting.nutrient_limits[7:0]);

      if (at > hi_t) begin
        if (!chamber.fan_hold) begin
          chamber.fan_hold = 1'b1;
          r[gcrc_pkg::BIT_FAN] = 1'b1;
        end
      end else if (at < hi_t - int'(gcrc_pkg::TEMP_BAND)) begin
        chamber.fan_hold = 1'b0;
        r[gcrc_pkg::BIT_FAN] = 1'b0;
      end
      if (at < lo_t) begin
        if (!chamber.heat_hold) begin
          chamber.heat_hold = 1'b1;
          r[gcrc_pkg::BIT_HEATER] = 1'b1;
        end
      end else if (at > lo_t + int'(gcrc_pkg::TEMP_BAND)) begin
        chamber.heat_hold = 1'b0;
        r[gcrc_pkg::BIT_HEATER] = 1'b0;
      end

      if (t.humidity < setting.hum_lo_pct) begin
        if (!chamber.fog_active) begin
          chamber.fog_active = 1'b1;
          chamber.fog_state = gcrc_pkg::FOG_SPRAYING;
          chamber.fog_mark = t.now_seconds;
          r[gcrc_pkg::BIT_FOG] = 1'b1;
        end
      end else if (int'(t.humidity) > int'(setting.hum_lo_pct) + int'(gcrc_pkg::HUM_BAND)) begin
        chamber.fog_active = 1'b0;
        chamber.fog_state = gcrc_pkg::FOG_STOPPED;
        r[gcrc_pkg::BIT_FOG] = 1'b0;
      end
      if (chamber.fog_active) begin
        elapsed = t.now_seconds - chamber.fog_mark;
        if (chamber.fog_state == gcrc_pkg::FOG_SPRAYING) begin
          if (elapsed >= {16'h0, setting.fog_timing[15:0]}) begin
            chamber.fog_state = gcrc_pkg::FOG_PAUSING;
            chamber.fog_mark = t.now_seconds;
            r[gcrc_pkg::BIT_FOG] = 1'b0;
          end
        end else if (chamber.fog_state == gcrc_pkg::FOG_PAUSING) begin
          if (elapsed >= {16'h0, setting.fog_timing[31:16]}) begin
            chamber.fog_state = gcrc_pkg::FOG_SPRAYING;
            chamber.fog_mark = t.now_seconds;
            r[gcrc_pkg::BIT_FOG] = 1'b1;
          end
        end
      end
      if (t.humidity > setting.hum_hi_pct) r[gcrc_pkg::BIT_FAN] = 1'b1;
      if (t.co2_ppm > setting.co2_limit) r[gcrc_pkg::BIT_FAN] = 1'b1;

      if (t.light_lux < setting.light_limits[15:0]) r[gcrc_pkg::BIT_LIGHT] = 1'b1;
      else if (t.light_lux > setting.light_limits[31:16]) r[gcrc_pkg::BIT_LIGHT] = 1'b0;

      if (nt > cool_t) begin
        r[gcrc_pkg::BIT_COOLER] = 1'b1;
        r[gcrc_pkg::BIT_HEATER] = 1'b0;
      end else if (nt < cool_t - int'(gcrc_pkg::TEMP_BAND)) begin
        r[gcrc_pkg::BIT_COOLER] = 1'b0;
      end
      if (nt < heat_t) begin
        r[gcrc_pkg::BIT_HEATER] = 1'b1;
        r[gcrc_pkg::BIT_COOLER] = 1'b0;
      end else if (nt > heat_t + int'(gcrc_pkg::TEMP_BAND)) begin
        r[gcrc_pkg::BIT_HEATER] = 1'b0;
      end

      if (!t.water_valid || t.water_low) r[gcrc_pkg::BIT_PUMP] = 1'b0;
    end
    chamber.relay = r;
    res.relay_byte = r;
    res.fog_step = chamber.fog_state;
    return res;
  endfunction

  function automatic gcrc_pkg::gcrc_item_t calm_tick(logic [31:0] now);
    gcrc_pkg::gcrc_item_t t;
    t = '0;
    t.mode = MODE_AUTO;
    t.now_seconds = now;
    t.air_temp = 8'd25;
    t.humidity = 7'd70;
    t.co2_ppm = 16'd400;
    t.light_lux = 16'd10000;
    t.nutr_temp = 8'd24;
    t.water_valid = 1'b1;
    return t;
  endfunction

  // Cluster fields around the current thresholds, with full-range values mixed in.
  function automatic gcrc_pkg::gcrc_item_t random_tick();
    gcrc_pkg::gcrc_item_t t;
    if ($urandom_range(49) == 0) tick_now = $urandom;
    else tick_now += $urandom_range(3);
    t.mode = ($urandom_range(99) < 12) ? gcrc_pkg::MODE_MANUAL : MODE_AUTO;
    t.manual_mask = 8'($urandom);
    t.now_seconds = tick_now;
    case ($urandom_range(3))
      0: t.air_temp = 8'(near(sdeg(setting.air_temp_high), 4));
      1: t.air_temp = 8'(near(sdeg(setting.air_temp_low), 4));
      default: t.air_temp = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: t.humidity = 7'(near(int'(setting.hum_lo_pct), 7));
      1: t.humidity = 7'(near(int'(setting.hum_hi_pct), 3));
      default: t.humidity = 7'($urandom);
    endcase
    if ($urandom_range(1) == 0) t.co2_ppm = near(int'(setting.co2_limit), 3);
    else t.co2_ppm = 16'($urandom);
    case ($urandom_range(3))
      0: t.light_lux = near(int'(setting.light_limits[15:0]), 3);
      1: t.light_lux = near(int'(setting.light_limits[31:16]), 3);
      default: t.light_lux = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: t.nutr_temp = 8'(near(sdeg(setting.nutrient_limits[15:8]), 4));
      1: t.nutr_temp = 8'(near(sdeg(setting.nutrient_limits[7:0]), 4));
      default: t.nutr_temp = 8'($urandom);
    endcase
    t.water_valid = 1'($urandom_range(1));
    t.water_low = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic send_tick(gcrc_pkg::gcrc_item_t t);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tick <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_relays.push_back(advance_chamber(t));
  endtask

  // Drop valid and hold until every pending result is out.
  task automatic wait_until_settled();
    in_valid <= 1'b0;
    while (expected_relays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers; unused upper data bits carry noise.
  task automatic write_setting(gcrc_pkg::gcrc_cfg_t s);
    logic [31:0] words [8];
    wait_until_settled();
    words[gcrc_pkg::REG_AIR_TEMP_HIGH]   = {24'($urandom), s.air_temp_high};
    words[gcrc_pkg::REG_AIR_TEMP_LOW]    = {24'($urandom), s.air_temp_low};
    words[gcrc_pkg::REG_HUMIDITY_LOW]    = {25'($urandom), s.hum_lo_pct};
    words[gcrc_pkg::REG_HUMIDITY_HIGH]   = {25'($urandom), s.hum_hi_pct};
    words[gcrc_pkg::REG_FOG_TIMING]      = s.fog_timing;
    words[gcrc_pkg::REG_CO2_HIGH]        = {16'($urandom), s.co2_limit};
    words[gcrc_pkg::REG_LIGHT_LIMITS]    = s.light_limits;
    words[gcrc_pkg::REG_NUTRIENT_LIMITS] = {16'($urandom), s.nutrient_limits};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= words[i];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
    end
    cfg_valid <= 1'b0;
    setting = s;
  endtask

  task automatic set_pressure(int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic test_directed_ticks();
    gcrc_pkg::gcrc_item_t t;
    logic [31:0] s;
    set_pressure(0, 0);
    // coldest and driest reading; fog starts just before the seconds counter wraps
    t = calm_tick(32'hFFFF_FFF0);
    t.air_temp = 8'h80;
    t.humidity = 7'd0;
    t.co2_ppm = 16'h0000;
    t.light_lux = 16'h0000;
    t.nutr_temp = 8'h80;
    send_tick(t);
    t = calm_tick(32'hFFFF_FFF5);
    t.humidity = 7'd10;
    send_tick(t);
    // manual ticks keep the fog phase
    t = calm_tick(32'hFFFF_FFF8);
    t.mode = gcrc_pkg::MODE_MANUAL;
    t.manual_mask = 8'hFF;
    send_tick(t);
    t.manual_mask = 8'hC0;
    send_tick(t);
    // pause measured across the wrap: one second short, then reached
    t = calm_tick(32'h0000_0012);
    t.air_temp = 8'h7F;
    t.humidity = 7'd0;
    t.co2_ppm = 16'hFFFF;
    t.light_lux = 16'hFFFF;
    t.nutr_temp = 8'h7F;
    t.water_valid = 1'b0;
    t.water_low = 1'b1;
    send_tick(t);
    t = calm_tick(32'h0000_0013);
    t.humidity = 7'd0;
    t.air_temp = 8'd34;
    send_tick(t);
    s = 32'h20;
    t = calm_tick(s++); t.humidity = 7'h7F; t.air_temp = 8'd33; send_tick(t);
    t = calm_tick(s++); t.humidity = 7'd55; t.air_temp = 8'd32; send_tick(t);
    t = calm_tick(s++); t.humidity = 7'd49; t.air_temp = 8'd14; send_tick(t);
    t = calm_tick(s++); t.air_temp = 8'd17; t.nutr_temp = 8'd17; send_tick(t);
    t = calm_tick(s++); t.air_temp = 8'd18; t.co2_ppm = 16'd2001; send_tick(t);
    t = calm_tick(s++); t.humidity = 7'd86; t.light_lux = 16'd5000; send_tick(t);
    t = calm_tick(s++); t.light_lux = 16'd4999; t.nutr_temp = 8'd31; send_tick(t);
    t = calm_tick(s++); t.light_lux = 16'd25001; t.nutr_temp = 8'd28; send_tick(t);
    t = calm_tick(s++); t.nutr_temp = 8'd27; send_tick(t);
    t = calm_tick(s++); t.nutr_temp = 8'd21; send_tick(t);
    // pump is only set by hand; then cleared by invalid and by low water
    t = calm_tick(s++); t.mode = gcrc_pkg::MODE_MANUAL; t.manual_mask = 8'h3F; send_tick(t);
    t = calm_tick(s++); send_tick(t);
    t = calm_tick(s++); t.water_valid = 1'b0; send_tick(t);
    t = calm_tick(s++); t.mode = gcrc_pkg::MODE_MANUAL; t.manual_mask = 8'h20; send_tick(t);
    t = calm_tick(s++); t.water_low = 1'b1; send_tick(t);
  endtask

  task automatic test_setting_extremes();
    gcrc_pkg::gcrc_cfg_t s;
    set_pressure(34, 34);
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: s = '0;
        1: begin
          s.air_temp_high = 8'h7F;
          s.air_temp_low = 8'h80;
          s.hum_lo_pct = 7'h7F;
          s.hum_hi_pct = 7'h7F;
          s.fog_timing = '1;
          s.co2_limit = '1;
          s.light_limits = '1;
          s.nutrient_limits = 16'h7F80;
        end
        2: begin
          // inverted thresholds; zero spray time sends a fresh start straight to pausing
          s.air_temp_high = 8'h80;
          s.air_temp_low = 8'h7F;
          s.hum_lo_pct = 7'd100;
          s.hum_hi_pct = 7'd0;
          s.fog_timing = 32'h0003_0000;
          s.co2_limit = 16'd1;
          s.light_limits = 32'h0000_FFFF;
          s.nutrient_limits = 16'h807F;
        end
        3: begin
          s = default_setting();
          s.fog_timing = 32'h0000_0002;
        end
        default: s = random_setting();
      endcase
      write_setting(s);
      repeat (50) send_tick(random_tick());
    end
  endtask

  // Mostly dry air with short timing so the fog cycles through spray and pause.
  task automatic test_fog_cycles();
    gcrc_pkg::gcrc_cfg_t s;
    gcrc_pkg::gcrc_item_t t;
    int pick;
    for (int k = 0; k < 4; k++) begin
      s = random_setting();
      s.fog_timing = {16'($urandom_range(4)), 16'($urandom_range(4))};
      s.hum_lo_pct = 7'($urandom_range(60, 40));
      write_setting(s);
      if (k % 2 == 0) set_pressure(76, 0);
      else set_pressure(0, 76);
      repeat (60) begin
        t = random_tick();
        pick = $urandom_range(99);
        if (pick < 85) t.humidity = 7'($urandom_range(int'(s.hum_lo_pct) - 1));
        else if (pick < 95) t.humidity = 7'(int'(s.hum_lo_pct) + $urandom_range(5));
        else t.humidity = 7'(int'(s.hum_lo_pct) + 6 + $urandom_range(20));
        send_tick(t);
      end
    end
  endtask

  task automatic test_random_ticks();
    int idle_by_phase [4] = '{0, 76, 0, 34};
    int stall_by_phase [4] = '{0, 0, 76, 34};
    for (int k = 0; k < 4; k++) begin
      write_setting(random_setting());
      set_pressure(idle_by_phase[k], stall_by_phase[k]);
      repeat (210) send_tick(random_tick());
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10) $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin : check_results
    relay_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_relays.size() == 0) begin
        if (mismatches < 10)
          $display("result with no pending item: relay %0h, fog %0d", out_relay_byte,
                   out_fog_step);
        mismatches++;
      end else begin
        want = expected_relays.pop_front();
        if (out_relay_byte !== want.relay_byte)
          report_mismatch("relay_byte", want.relay_byte, out_relay_byte);
        if (out_fog_step !== want.fog_step)
          report_mismatch("fog_step", want.fog_step, out_fog_step);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("grow_chamber_relay_controller test failed");
      $finish;
    end
  end

  initial begin
    setting = default_setting();
    chamber = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ticks();
    test_setting_extremes();
    test_fog_cycles();
    test_random_ticks();
    wait_until_settled();
    repeat (8) @(posedge clk);
    if (expected_relays.size() != 0)
      $display("%0d results never arrived", expected_relays.size());
    if (mismatches == 0 && expected_relays.size() == 0) begin
      $display("grow_chamber_relay_controller test passed");
    end else begin
      $display("grow_chamber_relay_controller test failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/gcrc_pkg.sv
hdl/gcrc_tick.sv
hdl/grow_chamber_relay_controller.sv
bench/testbench.sv
